@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/cpwc_pkg.sv @@
// Constants and controller/datapath interface types for the cold page counter.
package cpwc_pkg;

  localparam int NODES       = 4;
  localparam int PAGES       = 4096;
  localparam int MAX_WINDOWS = 15;

  localparam int NODE_W  = 2;
  localparam int PAGE_W  = 12;
  localparam int LEN_W   = 13;
  localparam int FREQ_W  = 16;
  localparam int CNT_W   = 8;

  localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PG_AW     = $clog2(PAGES);
  localparam int MEM_AW    = NODE_AW + PG_AW;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 8;
  localparam int M_USER_W = 2;

  typedef struct packed {
    logic accept;    // take the input beat
    logic init_clr;  // post-reset clear of the whole counter RAM
    logic node_clr;  // clear the pages of the captured node
    logic update;    // read-modify-write and load the result register
  } cpwc_cmd_t;

  typedef struct packed {
    logic rebuild_in;  // input beat changes its node's window length
    logic init_last;   // last address of the full clear
    logic node_last;   // last page of the node clear
    logic out_free;    // result register can take a new result
  } cpwc_sts_t;

endpackage

@@ rtl/cpwc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cpwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cpwc_ctrl.sv @@
// Controller: sequences reset clear, node clears and counter updates.
module cpwc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  input  cpwc_pkg::cpwc_sts_t sts,
  output cpwc_pkg::cpwc_cmd_t cmd,
  output logic               s_ready
);

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_CLEAR  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_ready      = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.init_clr = 1'b1;
        if (sts.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.rebuild_in ? ST_CLEAR : ST_UPDATE;
        end
      end
      ST_CLEAR: begin
        cmd.node_clr = 1'b1;
        if (sts.node_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

@@ rtl/cpwc_dp.sv @@
// Datapath: length table, clear sweep counter, counter RAM and result register.
module cpwc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  cpwc_pkg::cpwc_cmd_t          cmd,
  output cpwc_pkg::cpwc_sts_t          sts,
  input  logic [cpwc_pkg::NODE_W-1:0]  node_in,
  input  logic                         tracked_in,
  input  logic [cpwc_pkg::PAGE_W-1:0]  page_in,
  input  logic [cpwc_pkg::LEN_W-1:0]   len_in,
  input  logic [cpwc_pkg::FREQ_W-1:0]  freq_in,
  input  logic                         white_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cpwc_pkg::CNT_W-1:0]   out_count,
  output logic                         out_rebuilt,
  output logic                         out_skip
);

  logic [cpwc_pkg::LEN_W-1:0] npc [cpwc_pkg::NODES];

  logic [cpwc_pkg::NODE_AW-1:0] node_q;
  logic [cpwc_pkg::PG_AW-1:0]   page_q;
  logic                         cold_q;
  logic                         hit_q;
  logic                         rebuilt_q;

  logic [cpwc_pkg::MEM_AW-1:0] sweep;
  logic [cpwc_pkg::MEM_AW-1:0] addr_in, addr_q, raddr, waddr;
  logic [cpwc_pkg::CNT_W-1:0]  rdata, wdata, cur, cnt_next;
  logic                        we, active_in, inwin_in, clearing;

  assign active_in = tracked_in && (32'(node_in) < cpwc_pkg::NODES) && (len_in != '0);
  assign inwin_in  = ({1'b0, page_in} < len_in) && (32'(page_in) < cpwc_pkg::PAGES);

  assign sts.rebuild_in = active_in && (npc[node_in[cpwc_pkg::NODE_AW-1:0]] != len_in);
  assign sts.init_last  = (sweep == cpwc_pkg::MEM_AW'(cpwc_pkg::MEM_DEPTH - 1));
  assign sts.node_last  = (sweep[cpwc_pkg::PG_AW-1:0] == cpwc_pkg::PG_AW'(cpwc_pkg::PAGES - 1));
  assign sts.out_free   = !out_valid || out_ready;

  assign addr_in = {node_in[cpwc_pkg::NODE_AW-1:0], page_in[cpwc_pkg::PG_AW-1:0]};
  assign addr_q  = {node_q, page_q};
  assign raddr   = cmd.accept ? addr_in : addr_q;

  // After a node clear the page counter is known to be zero.
  assign cur = rebuilt_q ? '0 : rdata;
  always_comb begin
    if (!cold_q) begin
      cnt_next = '0;
    end else if (cur < cpwc_pkg::CNT_W'(cpwc_pkg::MAX_WINDOWS)) begin
      cnt_next = cur + 1'b1;
    end else begin
      cnt_next = cur;
    end
  end

  assign clearing = cmd.init_clr || cmd.node_clr;
  assign we       = clearing || (cmd.update && hit_q);
  assign waddr    = cmd.init_clr ? sweep :
                    cmd.node_clr ? {node_q, sweep[cpwc_pkg::PG_AW-1:0]} : addr_q;
  assign wdata    = clearing ? '0 : cnt_next;

  cpwc_ram #(
    .WIDTH (cpwc_pkg::CNT_W),
    .DEPTH (cpwc_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if ((cmd.init_clr && sts.init_last) || (cmd.node_clr && sts.node_last)) begin
      sweep <= '0;
    end else if (clearing) begin
      sweep <= sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpwc_pkg::NODES; i++) begin
        npc[i] <= '0;
      end
    end else if (cmd.accept && sts.rebuild_in) begin
      npc[node_in[cpwc_pkg::NODE_AW-1:0]] <= len_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      node_q    <= node_in[cpwc_pkg::NODE_AW-1:0];
      page_q    <= page_in[cpwc_pkg::PG_AW-1:0];
      cold_q    <= (freq_in == '0) && !white_in;
      hit_q     <= active_in && inwin_in;
      rebuilt_q <= sts.rebuild_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_count   <= hit_q ? cnt_next : '0;
      out_rebuilt <= rebuilt_q;
      out_skip    <= !hit_q;
    end
  end

endmodule

@@ rtl/cold_page_window_counter.sv @@
// Consecutive cold-window counter per page of each memory node.
// Each accepted observation yields one result beat. An observation is an accept
// with counter RAM read, then an update and write-back, as the read-modify-write
// on the single-port-pair counter RAM requires; the update waits while the result
// register is full. One that changes its node's window length adds, before the
// update, a sweep clearing that node's 4096 page counters. After reset a clearing
// pass over all 16384 counter RAM entries runs before the first beat is accepted.
// The result register lets the next beat be accepted while a result waits on m_tready.
module cold_page_window_counter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // node_id[1:0], page_index[13:2], window_length[26:14], access_freq[42:27], zero pad
  input  logic [cpwc_pkg::S_DATA_W-1:0]  s_tdata,
  // node_tracked[0], whitelisted[1]
  input  logic [cpwc_pkg::S_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cold_count[7:0]
  output logic [cpwc_pkg::M_DATA_W-1:0]  m_tdata,
  // tracker_rebuilt[0], skipped[1]
  output logic [cpwc_pkg::M_USER_W-1:0]  m_tuser
);

  cpwc_pkg::cpwc_cmd_t cmd;
  cpwc_pkg::cpwc_sts_t sts;
  logic                rebuilt, skip;

  cpwc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .sts     (sts),
    .cmd     (cmd),
    .s_ready (s_tready)
  );

  cpwc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .node_in     (s_tdata[1:0]),
    .tracked_in  (s_tuser[0]),
    .page_in     (s_tdata[13:2]),
    .len_in      (s_tdata[26:14]),
    .freq_in     (s_tdata[42:27]),
    .white_in    (s_tuser[1]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_count   (m_tdata),
    .out_rebuilt (rebuilt),
    .out_skip    (skip)
  );

  assign m_tuser = {skip, rebuilt};

endmodule

@@ rtl/cpwc_checker.sv @@
// Port-level checker for the cold page counter, bound to the top level.
`include "assert_macros.svh"

module cpwc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [cpwc_pkg::S_DATA_W-1:0] s_tdata,
  input logic [cpwc_pkg::S_USER_W-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [cpwc_pkg::M_DATA_W-1:0] m_tdata,
  input logic [cpwc_pkg::M_USER_W-1:0] m_tuser
);

  // The clearing pass holds off input right after reset.
  `ASSERT_IMPLIES(a_init_hold, clk, rst, $past(rst), !s_tready)

  // One observation at a time: no accept on the cycle after an accept.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // A skipped observation reports a zero count.
  `ASSERT_IMPLIES(a_skip_zero, clk, rst, m_tvalid && m_tuser[1], m_tdata == '0)

  // Counts saturate.
  `ASSERT_IMPLIES(a_saturate, clk, rst, m_tvalid,
                  m_tdata <= cpwc_pkg::M_DATA_W'(cpwc_pkg::MAX_WINDOWS))

  // Stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind cold_page_window_counter cpwc_checker u_cpwc_checker (.*);
